// ----- hdl/npcs_pkg.sv -----
// Shared constants and types for the nearest palette color search unit.
`default_nettype none

package npcs_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int COMP_W          = 6;
    localparam int ENTRY_W         = 3 * COMP_W;
    localparam int INDEX_W         = 8;
    localparam int DIST_W          = 8;
    localparam int IDX_W           = $clog2(PALETTE_ENTRIES);
    localparam int CNT_W           = $clog2(PALETTE_ENTRIES + 1);

    localparam logic [DIST_W-1:0] START_BOUND = 8'd197;
    localparam logic [DIST_W-1:0] MAX_DIST    = 8'd189;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic               en;
        logic [IDX_W-1:0]   addr;
        logic [ENTRY_W-1:0] data;
    } t_wr_req;

endpackage

`default_nettype wire

// ----- hdl/npcs_palette_ram.sv -----
// Palette memory with per-entry valid bits so that unwritten entries read as zero.
`default_nettype none

module npcs_palette_ram (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  npcs_pkg::t_wr_req             i_wr,
    input  logic                          i_rd_en,
    input  logic [npcs_pkg::IDX_W-1:0]    i_rd_addr,
    output logic [npcs_pkg::ENTRY_W-1:0]  o_rd_data
);
    import npcs_pkg::*;

    logic [ENTRY_W-1:0]         r_mem [PALETTE_ENTRIES];
    logic [PALETTE_ENTRIES-1:0] r_valid;
    logic [ENTRY_W-1:0]         r_rd_data;
    logic                       r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_addr];
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

`default_nettype wire

// ----- hdl/nearest_palette_colour_search_unit.sv -----
// Top level: palette write and nearest color query by Manhattan distance.
//
//  channel   handshake          payload
//  request   start / busy       i_kind, i_entry_index, i_red, i_green, i_blue
//  result    o_done strobe      o_best_index, o_best_distance
//
// A write request gives no result.
// A query feeds one palette read per cycle to a single distance and compare
// unit, through the registered memory read and a register for the result;
// busy is high while the scan runs and low when the result is shown.
// Reset clears the palette through per-entry valid bits, with no clearing pass.
// The result is shown for one cycle and the receiver cannot stall it.
`default_nettype none

module nearest_palette_colour_search_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_kind,
    input  logic [npcs_pkg::INDEX_W-1:0]  i_entry_index,
    input  logic [npcs_pkg::COMP_W-1:0]   i_red,
    input  logic [npcs_pkg::COMP_W-1:0]   i_green,
    input  logic [npcs_pkg::COMP_W-1:0]   i_blue,
    output logic                          o_done,
    output logic [npcs_pkg::INDEX_W-1:0]  o_best_index,
    output logic [npcs_pkg::DIST_W-1:0]   o_best_distance
);
    import npcs_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    function automatic logic [COMP_W-1:0] abs_diff(input logic [COMP_W-1:0] a,
                                                   input logic [COMP_W-1:0] b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_rd_cnt, n_rd_cnt;
    logic                r_cmp_vld;
    logic [IDX_W-1:0]    r_cmp_idx;
    logic [COMP_W-1:0]   r_red, r_green, r_blue;
    logic [IDX_W-1:0]    r_best_idx, n_best_idx;
    logic [DIST_W-1:0]   r_best_dist, n_best_dist;
    logic                r_done;
    logic [INDEX_W-1:0]  r_out_index;
    logic [DIST_W-1:0]   r_out_dist;

    logic                accept;
    logic                query_go;
    logic                rd_en;
    logic                last_cmp;
    t_wr_req             wr;
    logic [ENTRY_W-1:0]  rd_data;
    logic [DIST_W-1:0]   cand_dist;

    assign busy     = (r_state == S_SCAN);
    assign accept   = start && !busy;
    assign query_go = accept && (i_kind == KIND_QUERY);

    assign wr.en   = accept && (i_kind == KIND_WRITE) &&
                     ({1'b0, i_entry_index} < (INDEX_W + 1)'(PALETTE_ENTRIES));
    assign wr.addr = IDX_W'(i_entry_index);
    assign wr.data = {i_red, i_green, i_blue};

    assign rd_en = (r_state == S_SCAN) && (r_rd_cnt < CNT_W'(PALETTE_ENTRIES));

    npcs_palette_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (wr),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_cnt[IDX_W-1:0]),
        .o_rd_data (rd_data)
    );

    assign cand_dist = DIST_W'(abs_diff(r_red,   rd_data[3*COMP_W-1:2*COMP_W]))
                     + DIST_W'(abs_diff(r_green, rd_data[2*COMP_W-1:COMP_W]))
                     + DIST_W'(abs_diff(r_blue,  rd_data[COMP_W-1:0]));

    assign last_cmp = r_cmp_vld && (r_cmp_idx == IDX_W'(PALETTE_ENTRIES - 1));

    always_comb begin
        n_state     = r_state;
        n_rd_cnt    = r_rd_cnt;
        n_best_idx  = r_best_idx;
        n_best_dist = r_best_dist;
        case (r_state)
            S_IDLE: begin
                if (query_go) begin
                    n_state     = S_SCAN;
                    n_rd_cnt    = '0;
                    n_best_idx  = '0;
                    n_best_dist = START_BOUND;
                end
            end
            S_SCAN: begin
                if (rd_en) begin
                    n_rd_cnt = r_rd_cnt + 1'b1;
                end
                if (r_cmp_vld && (cand_dist < r_best_dist)) begin
                    n_best_idx  = r_cmp_idx;
                    n_best_dist = cand_dist;
                end
                if (last_cmp) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_cnt  <= '0;
            r_cmp_vld <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_cnt  <= n_rd_cnt;
            r_cmp_vld <= rd_en;
            r_done    <= last_cmp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx   <= r_rd_cnt[IDX_W-1:0];
        r_best_idx  <= n_best_idx;
        r_best_dist <= n_best_dist;
        if (query_go) begin
            r_red   <= i_red;
            r_green <= i_green;
            r_blue  <= i_blue;
        end
        if (last_cmp) begin
            r_out_index <= INDEX_W'(n_best_idx);
            r_out_dist  <= n_best_dist;
        end
    end

    assign o_done          = r_done;
    assign o_best_index    = r_out_index;
    assign o_best_distance = r_out_dist;

`ifndef SYNTHESIS
    assert property (@(posedge i_clk) disable iff (!i_rst_n) o_done |-> !busy)
        else $error("Result strobe raised while a scan is still running.");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
                     o_done |-> (o_best_distance <= MAX_DIST))
        else $error("Reported distance exceeds the largest possible distance.");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) query_go |=> busy)
        else $error("Accepted query did not start a scan.");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cmp_vld |-> busy)
        else $error("Compare unit active outside of a scan.");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) o_done |=> !o_done)
        else $error("Result strobe lasted more than one cycle.");
`endif

endmodule

`default_nettype wire
